// File: hdl/assert_macros.svh
// Assertion helpers for the text buffer checker.
// Depends on nothing; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent at one edge implies consequent at the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/utgb_pkg.sv
// Shared types, constants and code point helpers for the UTF-16 text buffer.
// No dependencies.
`default_nettype none
package utgb_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CP_W     = 21;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_ERASE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [CP_W-1:0] ZWJ_CP = 21'h0200D;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] code_unit;
    logic [7:0]  erase_count;
    logic [5:0]  read_index;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  text_length;
    logic        was_truncated;
    logic [15:0] read_unit;
  } rsp_t;

  function automatic logic is_high(input logic [15:0] u);
    return (u >= 16'hD800) && (u <= 16'hDBFF);
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return (u >= 16'hDC00) && (u <= 16'hDFFF);
  endfunction

  function automatic logic [CP_W-1:0] pair_cp(input logic [15:0] hi, input logic [15:0] lo);
    return {1'b0, hi[9:0], lo[9:0]} + 21'h10000;
  endfunction

  function automatic logic is_ri(input logic [CP_W-1:0] c);
    return (c >= 21'h1F1E6) && (c <= 21'h1F1FF);
  endfunction

  function automatic logic is_ext(input logic [CP_W-1:0] c);
    return ((c >= 21'h00300) && (c <= 21'h0036F)) || ((c >= 21'h01AB0) && (c <= 21'h01AFF)) ||
           ((c >= 21'h01DC0) && (c <= 21'h01DFF)) || ((c >= 21'h020D0) && (c <= 21'h020FF)) ||
           ((c >= 21'h0FE00) && (c <= 21'h0FE0F)) || ((c >= 21'h0FE20) && (c <= 21'h0FE2F)) ||
           ((c >= 21'h1F3FB) && (c <= 21'h1F3FF)) || ((c >= 21'hE0020) && (c <= 21'hE007F)) ||
           ((c >= 21'hE0100) && (c <= 21'hE01EF));
  endfunction

  // Map a logical position to a ring address; sum stays below twice the depth.
  function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W+1-ADDR_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W+1)'(CAPACITY)) sum = sum - (CNT_W+1)'(CAPACITY);
    return sum[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/utf16_grapheme_bounded_text_buffer_core.sv
// Bounded UTF-16 text buffer: controller plus ring-addressed unit RAM.
// Depends on utgb_pkg and utgb_ram.
//
// Usage: drive cmd and raise start; the beat is taken at an edge where busy
// is low. One response beat follows, shown on rsp for one cycle with done
// high; the receiver cannot hold it off and must take it then.
// Clear finishes straight from idle. A read waits in S_RD_WAIT and an erase
// checks the new last unit in S_ER_LAST, unless the read index is at or beyond
// the length or the erase leaves the buffer empty. Append checks the last unit
// in S_APP_LAST, then finishes there or writes from S_FIT if no eviction is needed.
// An eviction scans the leading grapheme through the single RAM read port,
// fetching units through S_FETCH, S_U1 and S_U2 and then dropping in S_DROP.
// Eviction itself is a head pointer move, so the store never shifts.
// Synchronous reset empties the buffer and clears the truncation flag; the
// RAM contents stay as they are and are never read before being written.
`default_nettype none
module utf16_grapheme_bounded_text_buffer_core import utgb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd,
  output logic      done,
  output rsp_t      rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_APP_LAST, S_FIT, S_FETCH, S_U1, S_U2, S_DROP, S_ER_LAST, S_RD_WAIT
  } state_t;
  typedef enum logic [1:0] {PH_FIRST, PH_RI2, PH_EXT, PH_ZWJ} phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  cmd_t              cq, cq_next;
  logic [CNT_W-1:0]  n, n_next, pos, pos_next;
  logic [ADDR_W-1:0] head, head_next;
  logic              flag, flag_next;
  logic [15:0]       unit_a, unit_a_next;
  logic              done_next;
  rsp_t              rsp_next;

  logic              rd_en, wr_en;
  logic [CNT_W-1:0]  rd_lidx;
  logic [15:0]       rdata;

  utgb_ram #(.DEPTH(CAPACITY), .WIDTH(16)) u_ram (
    .clk(clk), .we(wr_en), .waddr(ring_addr(head, n)), .wdata(cq.code_unit),
    .re(rd_en), .raddr(ring_addr(head, rd_lidx)), .rdata(rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    logic finish, acc, eval;
    logic [15:0] rd;
    logic [CP_W-1:0] cp;
    logic [CNT_W-1:0] len, adv, d, nn;
    logic hi, lo, need;
    state_next  = state;
    phase_next  = phase;
    cq_next     = cq;
    n_next      = n;
    pos_next    = pos;
    head_next   = head;
    flag_next   = flag;
    unit_a_next = unit_a;
    done_next   = 1'b0;
    rsp_next    = rsp;
    rd_en = 1'b0; wr_en = 1'b0; rd_lidx = '0;
    finish = 1'b0; acc = 1'b0; rd = '0; eval = 1'b0;
    cp = '0; len = '0; d = '0; nn = '0;
    hi = is_high(cq.code_unit);
    lo = is_low(cq.code_unit);
    need = hi ? ({1'b0, n} + (CNT_W+1)'(2) > (CNT_W+1)'(CAPACITY))
              : (n >= CNT_W'(CAPACITY));
    case (state)
      S_IDLE: begin
        if (start) begin
          cq_next = cmd;
          case (cmd.mode)
            MODE_APPEND: begin
              rd_en = (n != '0);
              rd_lidx = n - CNT_W'(1);
              state_next = S_APP_LAST;
            end
            MODE_ERASE: begin
              if (cmd.erase_count >= {{(8-CNT_W){1'b0}}, n}) begin
                n_next = '0; flag_next = 1'b0; finish = 1'b1;
              end else begin
                nn = n - cmd.erase_count[CNT_W-1:0];
                n_next = nn;
                if (nn != '0) begin
                  rd_en = 1'b1; rd_lidx = nn - CNT_W'(1); state_next = S_ER_LAST;
                end else begin
                  finish = 1'b1;
                end
              end
            end
            MODE_CLEAR: begin
              n_next = '0; flag_next = 1'b0; finish = 1'b1;
            end
            default: begin
              if ({1'b0, cmd.read_index} < n) begin
                rd_en = 1'b1; rd_lidx = {1'b0, cmd.read_index}; state_next = S_RD_WAIT;
              end else begin
                finish = 1'b1;
              end
            end
          endcase
        end
      end
      S_APP_LAST: begin
        if (n != '0 && is_high(rdata)) begin
          if (lo && n < CNT_W'(CAPACITY)) begin
            wr_en = 1'b1; n_next = n + CNT_W'(1); acc = 1'b1; finish = 1'b1;
          end else begin
            n_next = n - CNT_W'(1); flag_next = 1'b1;
            if (lo) finish = 1'b1;
            else state_next = S_FIT;
          end
        end else if (lo) begin
          flag_next = 1'b1; finish = 1'b1;
        end else begin
          state_next = S_FIT;
        end
      end
      S_FIT: begin
        if (need) begin
          pos_next = '0; phase_next = PH_FIRST; state_next = S_FETCH;
        end else if (n >= CNT_W'(CAPACITY)) begin
          finish = 1'b1;
        end else begin
          wr_en = 1'b1; n_next = n + CNT_W'(1); acc = 1'b1; finish = 1'b1;
        end
      end
      S_FETCH: begin
        if (pos >= n) begin
          state_next = S_DROP;
        end else begin
          rd_en = 1'b1; rd_lidx = pos; state_next = S_U1;
        end
      end
      S_U1: begin
        unit_a_next = rdata;
        if (is_high(rdata) && (pos + CNT_W'(1) < n)) begin
          rd_en = 1'b1; rd_lidx = pos + CNT_W'(1); state_next = S_U2;
        end else begin
          cp = {5'd0, rdata}; len = CNT_W'(1); eval = 1'b1;
        end
      end
      S_U2: begin
        eval = 1'b1;
        if (is_low(rdata)) begin
          cp = pair_cp(unit_a, rdata); len = CNT_W'(2);
        end else begin
          cp = {5'd0, unit_a}; len = CNT_W'(1);
        end
      end
      S_DROP: begin
        d = pos;
        if (hi && pos == '0) begin
          flag_next = 1'b1; finish = 1'b1;
        end else begin
          if (pos == '0) d = n;
          head_next = ring_addr(head, d);
          n_next = n - d; flag_next = 1'b1; state_next = S_FIT;
        end
      end
      S_ER_LAST: begin
        if (is_high(rdata)) n_next = n - CNT_W'(1);
        finish = 1'b1;
      end
      S_RD_WAIT: begin
        rd = rdata; finish = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase

    // Classify the fetched code point for the leading-cluster scan.
    adv = pos + len;
    if (eval) begin
      state_next = S_FETCH;
      case (phase)
        PH_FIRST: begin
          pos_next = adv; phase_next = is_ri(cp) ? PH_RI2 : PH_EXT;
        end
        PH_RI2: begin
          if (is_ri(cp)) pos_next = adv;
          phase_next = PH_EXT;
        end
        PH_EXT: begin
          if (is_ext(cp)) begin
            pos_next = adv;
          end else if (cp == ZWJ_CP && adv < n) begin
            pos_next = adv; phase_next = PH_ZWJ;
          end else begin
            state_next = S_DROP;
          end
        end
        default: begin
          pos_next = adv; phase_next = PH_EXT;
        end
      endcase
    end

    if (finish) begin
      state_next = S_IDLE;
      done_next = 1'b1;
      rsp_next.accepted = acc;
      rsp_next.text_length = 7'(n_next);
      rsp_next.was_truncated = flag_next;
      rsp_next.read_unit = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_FIRST;
      n     <= '0;
      head  <= '0;
      flag  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      n     <= n_next;
      head  <= head_next;
      flag  <= flag_next;
      done  <= done_next;
    end
    cq     <= cq_next;
    pos    <= pos_next;
    unit_a <= unit_a_next;
    rsp    <= rsp_next;
  end
endmodule
`default_nettype wire

// File: hdl/utgb_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module utgb_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/utgb_checker.sv
// Port-level checker for the text buffer core, bound into the core module.
// Depends on utgb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module utgb_checker import utgb_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire cmd_t cmd,
  input wire logic done,
  input wire rsp_t rsp
);
  `ASSERT_HOLDS(a_done_idle, clk, rst, !done || !busy)
  `ASSERT_NEXT(a_start_moves, clk, rst, start && !busy, busy || done)
  `ASSERT_HOLDS(a_len_bound, clk, rst, !done || (rsp.text_length <= 7'(CAPACITY)))
  `ASSERT_HOLDS(a_acc_nonempty, clk, rst, !(done && rsp.accepted) || (rsp.text_length != 7'd0))
endmodule

bind utf16_grapheme_bounded_text_buffer_core utgb_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done), .rsp(rsp)
);
`default_nettype wire

// File: verif/testbench.sv
// Self-checking bench for the bounded UTF-16 text buffer core.
// Depends on utgb_pkg (cmd_t, rsp_t, mode codes, CAPACITY) and the core RTL.
`default_nettype none
module testbench;
  import utgb_pkg::*;

  typedef struct {
    cmd_t c;
    bit   drain;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy, done;
  rsp_t rsp;

  utf16_grapheme_bounded_text_buffer_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the buffer contents.
  logic [15:0] shadow_units [CAPACITY];
  int          shadow_len;
  bit          shadow_trunc;

  beat_t pending_beats[$];
  rsp_t  expected_rsps[$];
  int    mismatches, sent, checked, appends_taken, trunc_seen;
  bit    taken;

  function automatic bit unit_high(input logic [15:0] u);
    return u >= 16'hD800 && u <= 16'hDBFF;
  endfunction

  function automatic bit unit_low(input logic [15:0] u);
    return u >= 16'hDC00 && u <= 16'hDFFF;
  endfunction

  // Code point at a position; a valid surrogate pair spans two units.
  function automatic int point_at(input int pos, output int span);
    int a;
    a = shadow_units[pos];
    span = 1;
    if (unit_high(a) && pos + 1 < shadow_len && unit_low(shadow_units[pos+1])) begin
      span = 2;
      return 'h10000 + ((a - 'hD800) << 10) + (shadow_units[pos+1] - 'hDC00);
    end
    return a;
  endfunction

  function automatic bit regional(input int c);
    return c >= 'h1F1E6 && c <= 'h1F1FF;
  endfunction

  function automatic bit extender(input int c);
    return (c >= 'h0300 && c <= 'h036F) || (c >= 'h1AB0 && c <= 'h1AFF) ||
           (c >= 'h1DC0 && c <= 'h1DFF) || (c >= 'h20D0 && c <= 'h20FF) ||
           (c >= 'hFE00 && c <= 'hFE0F) || (c >= 'hFE20 && c <= 'hFE2F) ||
           (c >= 'h1F3FB && c <= 'h1F3FF) || (c >= 'hE0020 && c <= 'hE007F) ||
           (c >= 'hE0100 && c <= 'hE01EF);
  endfunction

  function automatic int lead_cluster_len();
    int pos, span, c, c2;
    if (shadow_len == 0) return 0;
    c = point_at(0, span);
    pos = span;
    if (regional(c) && pos < shadow_len) begin
      c2 = point_at(pos, span);
      if (regional(c2)) pos += span;
    end
    while (pos < shadow_len) begin
      c = point_at(pos, span);
      if (extender(c)) begin
        pos += span;
        continue;
      end
      if (c != 'h200D || pos + span >= shadow_len) break;
      pos += span;
      void'(point_at(pos, span));
      pos += span;
    end
    return pos;
  endfunction

  function automatic void evict_front(input int n);
    for (int i = n; i < shadow_len; i++) shadow_units[i-n] = shadow_units[i];
    shadow_len -= n;
    shadow_trunc = 1'b1;
  endfunction

  function automatic bit append_unit(input logic [15:0] v);
    bit hi, lo;
    int d;
    hi = unit_high(v);
    lo = unit_low(v);
    if (shadow_len != 0 && unit_high(shadow_units[shadow_len-1])) begin
      if (lo && shadow_len < CAPACITY) begin
        shadow_units[shadow_len] = v;
        shadow_len += 1;
        return 1'b1;
      end
      // drop the dangling high surrogate
      shadow_len--;
      shadow_trunc = 1'b1;
      if (lo) return 1'b0;
    end else if (lo) begin
      shadow_trunc = 1'b1;
      return 1'b0;
    end
    if (hi) begin
      while (shadow_len + 2 > CAPACITY) begin
        d = lead_cluster_len();
        if (d == 0 || d > shadow_len) begin
          shadow_trunc = 1'b1;
          return 1'b0;
        end
        evict_front(d);
      end
    end else if (shadow_len >= CAPACITY) begin
      d = lead_cluster_len();
      if (d == 0 || d > shadow_len) d = shadow_len;
      evict_front(d);
    end
    if (shadow_len >= CAPACITY) return 1'b0;
    shadow_units[shadow_len] = v;
    shadow_len += 1;
    return 1'b1;
  endfunction

  function automatic rsp_t predict_response(input cmd_t c);
    rsp_t r;
    r = '0;
    case (c.mode)
      MODE_APPEND: r.accepted = append_unit(c.code_unit);
      MODE_ERASE: begin
        if (c.erase_count >= shadow_len) begin
          shadow_len = 0;
          shadow_trunc = 1'b0;
        end else begin
          shadow_len -= c.erase_count;
          if (shadow_len != 0 && unit_high(shadow_units[shadow_len-1])) shadow_len--;
        end
      end
      MODE_CLEAR: begin
        shadow_len = 0;
        shadow_trunc = 1'b0;
      end
      default: begin
        if (c.read_index < shadow_len) r.read_unit = shadow_units[c.read_index];
      end
    endcase
    r.text_length = 7'(shadow_len);
    r.was_truncated = shadow_trunc;
    return r;
  endfunction

  function automatic void push_beat(input logic [1:0] m, input logic [15:0] u,
                                    input logic [7:0] n, input logic [5:0] idx,
                                    input bit drain = 1'b0);
    beat_t b;
    b.c.mode = m;
    b.c.code_unit = u;
    b.c.erase_count = n;
    b.c.read_index = idx;
    b.drain = drain;
    pending_beats.push_back(b);
  endfunction

  function automatic void push_unit(input logic [15:0] u);
    push_beat(MODE_APPEND, u, 8'($urandom), 6'($urandom));
  endfunction

  // Append one random cluster-shaped run of units, mostly well formed.
  function automatic void push_cluster();
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) push_unit(16'($urandom_range('h20, 'h7E)));
    else if (k < 35) push_unit(16'($urandom_range('h0300, 'h036F)));
    else if (k < 42) push_unit(16'h200D);
    else if (k < 52) begin
      push_unit(16'hD83C);
      push_unit(16'($urandom_range('hDDE6, 'hDDFF)));
    end else if (k < 57) begin
      push_unit(16'hD83C);
      push_unit(16'($urandom_range('hDFFB, 'hDFFF)));
    end else if (k < 62) begin
      push_unit(16'hDB40);
      push_unit(16'($urandom_range('hDC20, 'hDC7F)));
    end else if (k < 67) begin
      push_unit(16'hDB40);
      push_unit(16'($urandom_range('hDD00, 'hDDEF)));
    end else if (k < 72) push_unit(16'($urandom_range('hFE00, 'hFE0F)));
    else if (k < 78) begin
      push_unit(16'($urandom_range('hD800, 'hDBFF)));
      push_unit(16'($urandom_range('hDC00, 'hDFFF)));
    end else if (k < 82) push_unit(16'($urandom_range('hD800, 'hDBFF)));
    else if (k < 85) push_unit(16'($urandom_range('hDC00, 'hDFFF)));
    else push_unit(16'($urandom));
  endfunction

  // Driver: change inputs on the falling edge.
  always @(negedge clk) begin
    bit idle;
    int phase;
    phase = (sent / 300) % 4;
    idle = (phase == 1 && $urandom_range(0, 99) < 71) ||
           (phase == 3 && $urandom_range(0, 99) < 31);
    if (!rst && (!start || taken)) begin
      if (pending_beats.size() != 0 && !idle &&
          !(pending_beats[0].drain && expected_rsps.size() != 0)) begin
        cmd <= pending_beats[0].c;
        start <= 1'b1;
        void'(pending_beats.pop_front());
        sent++;
      end else begin
        start <= 1'b0;
      end
    end
    taken = 1'b0;
  end

  // Monitor: take beats and check responses on the rising edge.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (start && !busy) begin
        expected_rsps.push_back(predict_response(cmd));
        taken = 1'b1;
        if (cmd.mode == MODE_APPEND) appends_taken++;
      end
      if (done) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", rsp);
        end else begin
          want = expected_rsps.pop_front();
          checked++;
          if (rsp.was_truncated) trunc_seen++;
          if (rsp.accepted !== want.accepted || rsp.text_length !== want.text_length ||
              rsp.was_truncated !== want.was_truncated || rsp.read_unit !== want.read_unit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at response %0d: expected %p, got %p", checked, want, rsp);
          end
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part
    push_beat(MODE_READ, 16'h0, 8'h0, 6'd0);
    push_unit(16'h0041);
    push_unit(16'hD83D);
    push_unit(16'hDE00);
    push_beat(MODE_READ, 16'h0, 8'h0, 6'd1);
    push_beat(MODE_READ, 16'h0, 8'h0, 6'd2);
    push_beat(MODE_READ, 16'h0, 8'h0, 6'd63);
    push_unit(16'hDFFF);
    push_unit(16'hDBFF);
    push_unit(16'h0000);
    push_unit(16'hFFFF);
    push_unit(16'hD800);
    push_beat(MODE_ERASE, 16'h0, 8'd1, 6'd0);
    push_beat(MODE_ERASE, 16'h0, 8'd0, 6'd0);
    push_beat(MODE_ERASE, 16'hFFFF, 8'hFF, 6'h3F);
    push_unit(16'h0065);
    push_beat(MODE_CLEAR, 16'hFFFF, 8'hFF, 6'h3F, 1'b1);

    // fill with combining-heavy text, then overflow with a pair and a unit
    for (int i = 0; i < 64; i++) push_unit(i % 4 == 0 ? 16'h0061 : 16'h0301);
    push_unit(16'hD83D);
    push_unit(16'hDE00);
    push_unit(16'h0062);
    push_beat(MODE_READ, 16'h0, 8'h0, 6'd63, 1'b1);
    push_unit(16'hD83D);
    push_beat(MODE_CLEAR, 16'h0, 8'h0, 6'd0);

    while (sent + pending_beats.size() < 1150) begin
      int k;
      k = $urandom_range(0, 999);
      if (k < 780) push_cluster();
      else if (k < 850) push_beat(MODE_ERASE, 16'($urandom), 8'($urandom_range(0, 4)),
                                  6'($urandom));
      else if (k < 865) push_beat(MODE_ERASE, 16'($urandom), 8'($urandom), 6'($urandom));
      else if (k < 872) push_beat(MODE_CLEAR, 16'($urandom), 8'($urandom), 6'($urandom));
      else push_beat(MODE_READ, 16'($urandom), 8'($urandom), 6'($urandom),
                     $urandom_range(0, 99) == 0);
    end

    while (pending_beats.size() != 0 || expected_rsps.size() != 0 || start)
      @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d commands (%0d appends), checked %0d responses,", sent, appends_taken,
             checked);
    $display("%0d of them with the truncation flag set; %0d mismatches.", trunc_seen,
             mismatches);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+hdl
hdl/utgb_pkg.sv
hdl/utgb_ram.sv
hdl/utgb_checker.sv
hdl/utf16_grapheme_bounded_text_buffer_core.sv
verif/testbench.sv
